// ===== hdl/pfx_pkg.sv =====
// pfx_pkg: shared types and constants for the postfix evaluator
// no dependencies
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_FULL      = 3'd2;
    localparam logic [2:0] ERR_DIVZERO   = 3'd3;
    localparam logic [2:0] ERR_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } op_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load_ch;     // capture input beat and apply digit step
        logic push_acc;    // write accumulator to stack
        logic rd_b;        // read top
        logic rd_a;        // read top-1
        logic cap_b;
        logic cap_a;
        logic start_op;
        logic push_res;
        logic rd_top;
        logic emit;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic in_number;
        logic last;
        logic cnt_lt2;
        logic op_done;
    } sts_t;

endpackage

// ===== hdl/pfx_ram.sv =====
// pfx_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/pfx_alu.sv =====
// pfx_alu: multicycle arithmetic unit, add/sub/mul/div/pow
// depends on pfx_pkg
`timescale 1ns / 1ps

module pfx_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  pfx_pkg::op_t op,
    input  logic [31:0]  a,
    input  logic [31:0]  b,
    output logic         done,
    output logic [31:0]  result
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_POW  = 4'b0100,
        A_MUL  = 4'b1000
    } alu_st_t;

    alu_st_t     st_reg, st_next;
    logic [31:0] x_reg, x_next;      // dividend/quotient, base or multiplier
    logic [31:0] y_reg, y_next;      // divisor magnitude or exponent
    logic [32:0] rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  n_reg, n_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] rsh;
    logic [32:0] rdiff;
    logic [31:0] prod_lo;
    logic [31:0] mag_a, mag_b, q;

    assign mag_a   = a[31] ? 32'(-a) : a;
    assign mag_b   = b[31] ? 32'(-b) : b;
    assign rsh     = {rem_reg[31:0], x_reg[31]};
    assign rdiff   = rsh - {1'b0, y_reg};
    assign prod_lo = 32'(acc_reg * x_reg);
    assign q       = x_reg;

    always_comb
    begin
        st_next   = st_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        n_next    = n_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        unique case (st_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        pfx_pkg::OP_ADD:
                        begin
                            res_next  = a + b;
                            done_next = 1'b1;
                        end
                        pfx_pkg::OP_SUB:
                        begin
                            res_next  = a - b;
                            done_next = 1'b1;
                        end
                        pfx_pkg::OP_MUL:
                        begin
                            acc_next = a;
                            x_next   = b;
                            st_next  = A_MUL;
                        end
                        pfx_pkg::OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                x_next   = mag_a;
                                y_next   = mag_b;
                                rem_next = '0;
                                n_next   = 6'd32;
                                neg_next = a[31] ^ b[31];
                                st_next  = A_DIV;
                            end
                        end
                        default:
                        begin
                            if (b[31])
                            begin
                                if (a == 32'd1)
                                begin
                                    res_next = 32'd1;
                                end
                                else if (a == 32'hFFFF_FFFF)
                                begin
                                    res_next = b[0] ? 32'hFFFF_FFFF : 32'd1;
                                end
                                else
                                begin
                                    res_next = '0;
                                end
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = 32'd1;
                                x_next   = a;
                                y_next   = b;
                                n_next   = '0;
                                st_next  = A_POW;
                            end
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                res_next  = prod_lo;
                done_next = 1'b1;
                st_next   = A_IDLE;
            end
            A_DIV:
            begin
                if (rdiff[32])
                begin
                    rem_next = rsh;
                    x_next   = {x_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_next = rdiff;
                    x_next   = {x_reg[30:0], 1'b1};
                end
                n_next = n_reg - 6'd1;
                if (n_reg == 6'd1)
                begin
                    st_next = A_IDLE;
                    n_next  = '0;
                end
            end
            A_POW:
            begin
                // n_reg[0]: 0 multiply acc by base if bit set, 1 square base
                if (y_reg == '0)
                begin
                    res_next  = acc_reg;
                    done_next = 1'b1;
                    st_next   = A_IDLE;
                end
                else if (n_reg[0] == 1'b0)
                begin
                    if (y_reg[0])
                    begin
                        acc_next = prod_lo;
                    end
                    n_next = 6'd1;
                end
                else
                begin
                    x_next = 32'(x_reg * x_reg);
                    y_next = y_reg >> 1;
                    n_next = 6'd0;
                end
            end
            default:
            begin
                st_next = A_IDLE;
            end
        endcase
    end

    // division result goes out in the cycle after the last step
    logic div_fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= A_IDLE;
            done_reg    <= 1'b0;
            div_fin_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            done_reg    <= done_next;
            div_fin_reg <= (st_reg == A_DIV) && (n_reg == 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        n_reg   <= n_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg || div_fin_reg;
    assign result = div_fin_reg ? (neg_reg ? 32'(-q) : q) : res_reg;

endmodule

// ===== hdl/pfx_datapath.sv =====
// pfx_datapath: character decode, digit accumulator, stack ram, count, error
// depends on pfx_pkg, pfx_ram, pfx_alu
`timescale 1ns / 1ps

module pfx_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pfx_pkg::in_beat_t   in_beat,
    input  pfx_pkg::cmd_t       cmd,
    output pfx_pkg::sts_t       sts,
    output pfx_pkg::out_beat_t  out_beat
);

    logic [7:0]                 ch_reg;
    logic                       last_reg;
    logic [31:0]                acc_reg;
    logic                       innum_reg;
    logic [pfx_pkg::CNT_W-1:0]  cnt_reg;
    logic [2:0]                 err_reg, err_next;
    logic [31:0]                a_reg, b_reg;
    logic [31:0]                rdata;
    logic [pfx_pkg::PTR_W-1:0]  addr;
    logic                       we;
    logic [31:0]                wdata;
    logic                       full;
    logic                       dig;
    logic                       alu_done;
    logic [31:0]                alu_res;
    pfx_pkg::op_t               op;
    pfx_pkg::out_beat_t         out_reg;

    assign dig  = (in_beat.char_code >= pfx_pkg::CH_ZERO)
               && (in_beat.char_code <= pfx_pkg::CH_NINE);
    assign full = (cnt_reg == pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH));

    always_comb
    begin
        unique case (ch_reg)
            pfx_pkg::CH_PLUS:  op = pfx_pkg::OP_ADD;
            pfx_pkg::CH_MINUS: op = pfx_pkg::OP_SUB;
            pfx_pkg::CH_MUL:   op = pfx_pkg::OP_MUL;
            pfx_pkg::CH_DIV:   op = pfx_pkg::OP_DIV;
            default:           op = pfx_pkg::OP_POW;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = acc_reg;
        addr  = pfx_pkg::PTR_W'(cnt_reg - pfx_pkg::CNT_W'(1));
        if (cmd.push_acc || cmd.push_res)
        begin
            we    = !full;
            wdata = cmd.push_res ? alu_res : acc_reg;
            addr  = pfx_pkg::PTR_W'(cnt_reg);
        end
        else if (cmd.rd_a)
        begin
            addr = pfx_pkg::PTR_W'(cnt_reg - pfx_pkg::CNT_W'(2));
        end
    end

    pfx_ram #(
        .WIDTH (32),
        .DEPTH (pfx_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    pfx_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_op && (cnt_reg >= pfx_pkg::CNT_W'(2))),
        .op     (op),
        .a      (a_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_res)
    );

    always_comb
    begin
        err_next = err_reg;
        if (err_reg == pfx_pkg::ERR_NONE)
        begin
            if ((cmd.push_acc || cmd.push_res) && full)
            begin
                err_next = pfx_pkg::ERR_FULL;
            end
            else if (cmd.start_op && (cnt_reg < pfx_pkg::CNT_W'(2)))
            begin
                err_next = pfx_pkg::ERR_UNDERFLOW;
            end
            else if (cmd.start_op && (op == pfx_pkg::OP_DIV) && (b_reg == '0))
            begin
                err_next = pfx_pkg::ERR_DIVZERO;
            end
            else if (cmd.emit && (cnt_reg == '0))
            begin
                err_next = pfx_pkg::ERR_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            innum_reg <= 1'b0;
            cnt_reg   <= '0;
            err_reg   <= pfx_pkg::ERR_NONE;
        end
        else if (cmd.clear)
        begin
            acc_reg   <= '0;
            innum_reg <= 1'b0;
            cnt_reg   <= '0;
            err_reg   <= pfx_pkg::ERR_NONE;
        end
        else
        begin
            err_reg <= err_next;
            if (cmd.load_ch && dig)
            begin
                acc_reg   <= 32'(acc_reg * 32'd10) + {24'd0, in_beat.char_code - pfx_pkg::CH_ZERO};
                innum_reg <= 1'b1;
            end
            if (cmd.push_acc)
            begin
                acc_reg   <= '0;
                innum_reg <= 1'b0;
            end
            if ((cmd.push_acc || cmd.push_res) && !full)
            begin
                cnt_reg <= cnt_reg + pfx_pkg::CNT_W'(1);
            end
            if (cmd.start_op && (cnt_reg >= pfx_pkg::CNT_W'(2)))
            begin
                cnt_reg <= cnt_reg - pfx_pkg::CNT_W'(2);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ch)
        begin
            ch_reg   <= in_beat.char_code;
            last_reg <= in_beat.end_of_expr;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rdata;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.emit)
        begin
            out_reg.value  <= (cnt_reg == '0) ? '0 : rdata;
            out_reg.status <= err_next;
        end
    end

    assign sts.is_digit  = dig;
    assign sts.is_op     = (ch_reg == pfx_pkg::CH_PLUS) || (ch_reg == pfx_pkg::CH_MINUS)
                        || (ch_reg == pfx_pkg::CH_MUL) || (ch_reg == pfx_pkg::CH_DIV)
                        || (ch_reg == pfx_pkg::CH_POW);
    assign sts.in_number = innum_reg;
    assign sts.last      = last_reg;
    assign sts.cnt_lt2   = cnt_reg < pfx_pkg::CNT_W'(2);
    assign sts.op_done   = alu_done;
    assign out_beat      = out_reg;

endmodule

// ===== hdl/pfx_ctrl.sv =====
// pfx_ctrl: sequencing state machine for the postfix evaluator
// depends on pfx_pkg
`timescale 1ns / 1ps

module pfx_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  pfx_pkg::sts_t  sts,
    output pfx_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLOSE  = 11'b00000000010,
        S_DEC    = 11'b00000000100,
        S_RDB    = 11'b00000001000,
        S_RDA    = 11'b00000010000,
        S_CAPA   = 11'b00000100000,
        S_RUN    = 11'b00001000000,
        S_WAIT   = 11'b00010000000,
        S_FIN    = 11'b00100000000,
        S_EMIT   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t st_reg, st_next;
    logic   ov_reg, ov_next;
    logic   accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (st_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        st_next = st_reg;
        ov_next = ov_reg && out_stall;
        cmd     = '0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_ch = 1'b1;
                    st_next     = sts.is_digit ? S_DEC : S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.push_acc = sts.in_number;
                st_next      = S_DEC;
                if (!sts.is_op)
                begin
                    st_next = S_FIN;
                end
                else
                begin
                    st_next = S_RDB;
                end
            end
            S_DEC:
            begin
                st_next = S_FIN;
            end
            S_RDB:
            begin
                cmd.rd_b = 1'b1;
                st_next  = S_RDA;
            end
            S_RDA:
            begin
                cmd.rd_a  = 1'b1;
                cmd.cap_b = 1'b1;
                st_next   = S_CAPA;
            end
            S_CAPA:
            begin
                cmd.cap_a = 1'b1;
                st_next   = S_RUN;
            end
            S_RUN:
            begin
                cmd.start_op = 1'b1;
                st_next      = sts.cnt_lt2 ? S_FIN : S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.op_done)
                begin
                    cmd.push_res = 1'b1;
                    st_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!sts.last)
                begin
                    st_next = S_IDLE;
                end
                else
                begin
                    cmd.push_acc = sts.in_number;
                    st_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.rd_top = 1'b1;
                st_next    = S_OUT;
            end
            S_OUT:
            begin
                // wait until the output register is free or leaves this cycle
                if (!ov_reg || !out_stall)
                begin
                    cmd.emit  = 1'b1;
                    cmd.clear = 1'b1;
                    ov_next   = 1'b1;
                    st_next   = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (st_reg == S_IDLE && !accept && ov_reg == 1'b0)
        begin
            cmd.clear = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

endmodule

// ===== hdl/postfix_expression_evaluator_core.sv =====
// postfix_expression_evaluator_core: top level of the postfix evaluator
// a char is captured and decoded; an operator reads both operands, then starts the alu
// alu: add/sub direct, mul via a product state, restoring divide, square-and-multiply power
// end character then reads the stack top and emits; one character in flight at a time
// reset: asynchronous active low, clears count, accumulator, error and control
// depends on pfx_pkg, pfx_ctrl, pfx_datapath
`timescale 1ns / 1ps

module postfix_expression_evaluator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pfx_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pfx_pkg::out_beat_t  out_data
);

    pfx_pkg::cmd_t cmd;
    pfx_pkg::sts_t sts;

    pfx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfx_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_beat (out_data)
    );

endmodule

// ===== tb/tb_checker.sv =====
// tb_checker: watches both channels of the postfix evaluator, predicts results, compares
// depends on pfx_pkg
`timescale 1ns / 1ps

module tb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  pfx_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  pfx_pkg::out_beat_t out_data,
    output int                 fail_count,
    output int                 pending
);

    logic [31:0]        stk [pfx_pkg::STACK_DEPTH];
    int                 depth;
    logic [31:0]        accum;
    logic               digits_open;
    logic [2:0]         sticky;
    pfx_pkg::out_beat_t want_q [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        begin
            fail_count++;
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
        end
    endtask

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] pow32(input logic [31:0] base, input logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex[31])
        begin
            if (base == 32'd1)
                return 32'd1;
            if (base == 32'hFFFF_FFFF)
                return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (ex != 0)
        begin
            if (ex[0])
                acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    task automatic flag(input logic [2:0] code);
        begin
            if (sticky == pfx_pkg::ERR_NONE)
                sticky = code;
        end
    endtask

    task automatic push(input logic [31:0] v);
        begin
            if (depth >= pfx_pkg::STACK_DEPTH)
                flag(pfx_pkg::ERR_FULL);
            else
            begin
                stk[depth] = v;
                depth++;
            end
        end
    endtask

    task automatic close_run();
        begin
            if (digits_open)
            begin
                push(accum);
                accum = 0;
                digits_open = 0;
            end
        end
    endtask

    task automatic clear_state();
        begin
            depth = 0;
            accum = 0;
            digits_open = 0;
            sticky = pfx_pkg::ERR_NONE;
        end
    endtask

    task automatic eval_char(input pfx_pkg::in_beat_t b);
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        r;
        logic [31:0]        q;
        pfx_pkg::out_beat_t o;
        begin
            if (b.char_code >= pfx_pkg::CH_ZERO && b.char_code <= pfx_pkg::CH_NINE)
            begin
                accum = accum * 32'd10 + 32'(b.char_code - pfx_pkg::CH_ZERO);
                digits_open = 1;
            end
            else
            begin
                close_run();
                if (b.char_code inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_MUL,
                                        pfx_pkg::CH_DIV, pfx_pkg::CH_POW})
                begin
                    if (depth < 2)
                        flag(pfx_pkg::ERR_UNDERFLOW);
                    else
                    begin
                        y = stk[depth-1];
                        x = stk[depth-2];
                        depth -= 2;
                        case (b.char_code)
                            pfx_pkg::CH_PLUS:  r = x + y;
                            pfx_pkg::CH_MINUS: r = x - y;
                            pfx_pkg::CH_MUL:   r = x * y;
                            pfx_pkg::CH_DIV:
                            begin
                                if (y == 0)
                                begin
                                    flag(pfx_pkg::ERR_DIVZERO);
                                    r = 0;
                                end
                                else
                                begin
                                    q = mag(x) / mag(y);
                                    r = (x[31] ^ y[31]) ? -q : q;
                                end
                            end
                            default:  r = pow32(x, y);
                        endcase
                        push(r);
                    end
                end
            end
            if (b.end_of_expr)
            begin
                close_run();
                if (depth == 0)
                begin
                    o.value = 0;
                    flag(pfx_pkg::ERR_EMPTY);
                end
                else
                    o.value = stk[depth-1];
                o.status = sticky;
                want_q.push_back(o);
                clear_state();
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        clear_state();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                eval_char(in_data);
            if (out_valid && !out_stall)
            begin
                if (want_q.size() == 0)
                    report("unexpected beat", out_data.value, 0);
                else
                begin
                    if (out_data.value !== want_q[0].value)
                        report("value", out_data.value, want_q[0].value);
                    if (out_data.status !== want_q[0].status)
                        report("status", 32'(out_data.status), 32'(want_q[0].status));
                    void'(want_q.pop_front());
                end
            end
            pending = want_q.size();
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for postfix_expression_evaluator_core
// depends on pfx_pkg, tb_checker and the evaluator rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    pfx_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_stall;
    pfx_pkg::out_beat_t out_data;
    int                 fail_count;
    int                 pending;
    int                 gap_pct;
    int                 stall_pct;
    int                 hold_cycles;
    int                 quiet;

    postfix_expression_evaluator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    tb_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // valid stays up after the beat until the next send or drain drives it
    task automatic send(input logic [7:0] c, input logic last);
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= '{char_code: c, end_of_expr: last};
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic send_str(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                send(s[i], i == s.len() - 1);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(4))
            0: return pfx_pkg::CH_PLUS;
            1: return pfx_pkg::CH_MINUS;
            2: return pfx_pkg::CH_MUL;
            3: return pfx_pkg::CH_DIV;
            default: return pfx_pkg::CH_POW;
        endcase
    endfunction

    // well-formed expression with random content, sometimes noise or broken
    task automatic rand_expr();
        int nvals;
        int ndig;
        int live;
        logic [7:0] c;
        begin
            nvals = $urandom_range(1, 6);
            live = 0;
            for (int v = 0; v < nvals; v++)
            begin
                ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
                for (int d = 0; d < ndig; d++)
                    send(pfx_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
                send(($urandom_range(3) == 0) ? 8'h2C : 8'h20, 1'b0);
                live++;
                while (live >= 2 && $urandom_range(2) == 0)
                begin
                    send(pick_op(), 1'b0);
                    live--;
                end
                if ($urandom_range(19) == 0)
                    send(8'($urandom), 1'b0);
            end
            while (live > 1 && $urandom_range(7) != 0)
            begin
                send(pick_op(), 1'b0);
                live--;
            end
            if ($urandom_range(5) == 0)
                c = 8'($urandom);
            else if ($urandom_range(1) == 0)
                c = pick_op();
            else
                c = pfx_pkg::CH_ZERO + 8'($urandom_range(9));
            send(c, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        hold_cycles = 0;
        quiet = 0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_str("3 4+");
        send_str("10 3-2*");
        send_str("2147483647 1+");
        send_str("7 2/");
        send_str("5 0/");
        send_str("+");
        send_str(" ");
        send_str("2147483648 0 1-/");
        send_str("0 0^");
        send_str("1 0 1-^");
        send_str("1 1-3 0-^");
        send_str("7 2 0-^");
        send_str("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8");
        send_str("99999999999 3 2^^");
        send_str({8'hFF, 8'h00, 8'h80, "9"});
        drain();

        // random, three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 36 : (phase == 1) ? 49 : 0;
            stall_pct = (phase == 0) ? 49 : (phase == 1) ? 36 : 0;
            for (int k = 0; k < 40; k++)
            begin
                if (k == 20 && phase == 2)
                    hold_cycles <= 600;
                if (k == 28)
                    drain();
                rand_expr();
            end
        end
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
